>>> hdl/bam_pkg.sv
// shared constants, types and weight tables of the avoidance mode mixer
package bam_pkg;

    localparam int NUM_SENSORS = 8;
    localparam int SAMPLE_W    = 12;
    localparam int MIG_W       = 13;
    localparam int OUT_W       = 15;
    localparam int THR_W       = 12;
    localparam int OFFSET_W    = 11;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int WEIGHT_W    = 9;
    localparam int PIPE_DEPTH  = 4;

    // weighted sums: positive weights add up to 556, so eleven bits above a sample
    localparam int SUM_W  = SAMPLE_W + 11;
    localparam int MAG_W  = SUM_W - 1;
    // the divisor is at least 256, so the quotient loses eight bits
    localparam int QUOT_W = SUM_W - 8;

    // divide by reciprocal: exact for every magnitude below 2**MAG_W
    localparam int     BRAIT_DIVISOR = 350;
    localparam int     DIV_SHIFT     = MAG_W + 9;
    localparam int     DIVM_W        = DIV_SHIFT - 8;
    localparam longint DIV_MULT      =
        ((longint'(1) << DIV_SHIFT) + BRAIT_DIVISOR - 1) / BRAIT_DIVISOR;

    localparam int CALC_W = 18;

    typedef logic        [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MIG_W-1:0]    mig_t;
    typedef logic signed [OUT_W-1:0]    out_t;
    typedef logic        [THR_W-1:0]    thr_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [QUOT_W-1:0]   quot_t;
    typedef logic signed [CALC_W-1:0]   calc_t;

    localparam logic MODE_AVOID   = 1'b0;
    localparam logic MODE_MIGRATE = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_AVOID_THR    = 3'd0,
        CFG_EXIT_THR     = 3'd1,
        CFG_SPEED_LIMIT  = 3'd2,
        CFG_LEFT_OFFSET  = 3'd3,
        CFG_RIGHT_OFFSET = 3'd4
    } cfg_addr_t;

    localparam thr_t    AVOID_THR_RST    = 12'd1800;
    localparam thr_t    EXIT_THR_RST     = 12'd70;
    localparam thr_t    SPEED_LIMIT_RST  = 12'd800;
    localparam offset_t LEFT_OFFSET_RST  = 11'sd66;
    localparam offset_t RIGHT_OFFSET_RST = 11'sd72;

    localparam weight_t WEIGHT_RIGHT [NUM_SENSORS] = '{
        -9'sd2, 9'sd46, 9'sd149, 9'sd193, 9'sd168, -9'sd31, -9'sd164, -9'sd16
    };
    localparam weight_t WEIGHT_LEFT [NUM_SENSORS] = '{
        -9'sd16, -9'sd164, -9'sd31, 9'sd168, 9'sd193, 9'sd149, 9'sd46, -9'sd2
    };

    typedef struct packed {
        thr_t    avoid_threshold;
        thr_t    exit_threshold;
        thr_t    speed_limit;
        offset_t left_offset;
        offset_t right_offset;
    } cfg_t;

    typedef struct packed {
        sum_t    sum_left;
        sum_t    sum_right;
        sample_t max_sample;
        logic    front_hit;
        mig_t    mig_left;
        mig_t    mig_right;
    } weigh_t;

    typedef struct packed {
        quot_t quot_left;
        quot_t quot_right;
        logic  mode_used;
        logic  mode_next;
        mig_t  mig_left;
        mig_t  mig_right;
    } scale_t;

endpackage

>>> hdl/bam_ifs.sv
// valid/ready channels of the mixer: input item, result and register writes
interface bam_in_if;
    import bam_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sensor_0;
    sample_t sensor_1;
    sample_t sensor_2;
    sample_t sensor_3;
    sample_t sensor_4;
    sample_t sensor_5;
    sample_t sensor_6;
    sample_t sensor_7;
    mig_t    migrate_left;
    mig_t    migrate_right;

    modport source (
        output valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5,
               sensor_6, sensor_7, migrate_left, migrate_right,
        input  ready
    );
    modport sink (
        input  valid, sensor_0, sensor_1, sensor_2, sensor_3, sensor_4, sensor_5,
               sensor_6, sensor_7, migrate_left, migrate_right,
        output ready
    );
endinterface

interface bam_out_if;
    import bam_pkg::*;

    logic valid;
    logic ready;
    out_t left_speed;
    out_t right_speed;
    logic mode_used;
    logic mode_next;

    modport source (
        output valid, left_speed, right_speed, mode_used, mode_next,
        input  ready
    );
    modport sink (
        input  valid, left_speed, right_speed, mode_used, mode_next,
        output ready
    );
endinterface

interface bam_cfg_if;
    import bam_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (
        output valid, addr, wdata,
        input  ready
    );
    modport sink (
        input  valid, addr, wdata,
        output ready
    );
endinterface

>>> hdl/braitenberg_avoidance_mode_mixer.sv
// top level of the braitenberg avoidance mode mixer
//
//   channel  side  beat contents
//   item     in    sensor_0 .. sensor_7, migrate_left, migrate_right
//   result   out   left_speed, right_speed, mode_used, mode_next
//   cfg      in    addr (register index), wdata
//
// one item per cycle while results are taken; each item passes in order through the
// input register, sums register, divide/mode register and result register
// the divide stage holds the mode bit, updated as each beat passes it
// a stalled result backs up stage by stage; items are taken while any stage is free
// reset empties the pipeline, loads the register defaults and sets migration mode
// cfg is always ready and takes effect on the next cycle
module braitenberg_avoidance_mode_mixer (
    input  logic       clk,
    input  logic       rst_n,
    bam_in_if.sink     item,
    bam_out_if.source  result,
    bam_cfg_if.sink    cfg
);
    import bam_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   weigh_valid;
    logic   weigh_ready;
    weigh_t weigh_data;
    logic   scale_valid;
    logic   scale_ready;
    scale_t scale_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_addr_t'(cfg.addr))
                CFG_AVOID_THR:    cfg_next.avoid_threshold = THR_W'(cfg.wdata);
                CFG_EXIT_THR:     cfg_next.exit_threshold  = THR_W'(cfg.wdata);
                CFG_SPEED_LIMIT:  cfg_next.speed_limit     = THR_W'(cfg.wdata);
                CFG_LEFT_OFFSET:  cfg_next.left_offset     = offset_t'(cfg.wdata[OFFSET_W-1:0]);
                CFG_RIGHT_OFFSET: cfg_next.right_offset    = offset_t'(cfg.wdata[OFFSET_W-1:0]);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avoid_threshold <= AVOID_THR_RST;
            cfg_reg.exit_threshold  <= EXIT_THR_RST;
            cfg_reg.speed_limit     <= SPEED_LIMIT_RST;
            cfg_reg.left_offset     <= LEFT_OFFSET_RST;
            cfg_reg.right_offset    <= RIGHT_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bam_weigh u_weigh (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_regs (cfg_reg),
        .dn_valid (weigh_valid),
        .dn_ready (weigh_ready),
        .dn_data  (weigh_data)
    );

    bam_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .up_valid (weigh_valid),
        .up_ready (weigh_ready),
        .up_data  (weigh_data),
        .dn_valid (scale_valid),
        .dn_ready (scale_ready),
        .dn_data  (scale_data)
    );

    bam_limit u_limit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .up_valid (scale_valid),
        .up_ready (scale_ready),
        .up_data  (scale_data),
        .result   (result)
    );

endmodule

>>> hdl/bam_weigh.sv
// input register, braitenberg weighted sums, largest sample and front test
module bam_weigh (
    input  logic            clk,
    input  logic            rst_n,
    bam_in_if.sink          item,
    input  bam_pkg::cfg_t   cfg_regs,
    output logic            dn_valid,
    input  logic            dn_ready,
    output bam_pkg::weigh_t dn_data
);
    import bam_pkg::*;

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] sensor_reg;
    mig_t                                 mig_left_reg;
    mig_t                                 mig_right_reg;
    logic                                 weigh_valid_reg;
    logic                                 weigh_valid_next;
    weigh_t                               weigh_reg;
    weigh_t                               weigh_next;
    logic                                 weigh_ready;
    sum_t                                 acc_left;
    sum_t                                 acc_right;
    sample_t                              max_s;

    assign weigh_ready = !weigh_valid_reg || dn_ready;
    assign item.ready  = !in_valid_reg || weigh_ready;

    assign in_valid_next    = item.ready ? item.valid : in_valid_reg;
    assign weigh_valid_next = weigh_ready ? in_valid_reg : weigh_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            weigh_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            weigh_valid_reg <= weigh_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            sensor_reg[0] <= item.sensor_0;
            sensor_reg[1] <= item.sensor_1;
            sensor_reg[2] <= item.sensor_2;
            sensor_reg[3] <= item.sensor_3;
            sensor_reg[4] <= item.sensor_4;
            sensor_reg[5] <= item.sensor_5;
            sensor_reg[6] <= item.sensor_6;
            sensor_reg[7] <= item.sensor_7;
            mig_left_reg  <= item.migrate_left;
            mig_right_reg <= item.migrate_right;
        end
        if (in_valid_reg && weigh_ready)
        begin
            weigh_reg <= weigh_next;
        end
    end

    // constant weights, so each product reduces to a few adds
    always_comb
    begin
        acc_left  = '0;
        acc_right = '0;
        max_s     = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            acc_right = acc_right
                + sum_t'(signed'({1'b0, sensor_reg[i]})) * sum_t'(WEIGHT_RIGHT[i]);
            acc_left  = acc_left
                + sum_t'(signed'({1'b0, sensor_reg[i]})) * sum_t'(WEIGHT_LEFT[i]);
            if (sensor_reg[i] > max_s)
            begin
                max_s = sensor_reg[i];
            end
        end
    end

    always_comb
    begin
        weigh_next.sum_left   = acc_left;
        weigh_next.sum_right  = acc_right;
        weigh_next.max_sample = max_s;
        weigh_next.front_hit  = (sensor_reg[0] > cfg_regs.avoid_threshold)
                             || (sensor_reg[1] > cfg_regs.avoid_threshold)
                             || (sensor_reg[6] > cfg_regs.avoid_threshold)
                             || (sensor_reg[7] > cfg_regs.avoid_threshold);
        weigh_next.mig_left   = mig_left_reg;
        weigh_next.mig_right  = mig_right_reg;
    end

    assign dn_valid = weigh_valid_reg;
    assign dn_data  = weigh_reg;

endmodule

>>> hdl/bam_scale.sv
// division of both sums by the constant divisor and the mode register
module bam_scale (
    input  logic            clk,
    input  logic            rst_n,
    input  bam_pkg::cfg_t   cfg_regs,
    input  logic            up_valid,
    output logic            up_ready,
    input  bam_pkg::weigh_t up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output bam_pkg::scale_t dn_data
);
    import bam_pkg::*;

    localparam logic [DIVM_W-1:0] DIVM = DIVM_W'(DIV_MULT);

    logic   mode_reg;
    logic   mode_next;
    logic   mode_used;
    logic   valid_reg;
    logic   valid_next;
    logic   load;
    scale_t scale_reg;
    scale_t scale_next;

    // truncating division: magnitude times reciprocal, then sign back
    function automatic quot_t div_const(input sum_t v);
        logic [MAG_W-1:0]        mag;
        logic [MAG_W+DIVM_W-1:0] prod;
        quot_t                   q;
        mag  = v[SUM_W-1] ? MAG_W'(-v) : MAG_W'(v);
        prod = (MAG_W+DIVM_W)'(mag) * (MAG_W+DIVM_W)'(DIVM);
        q    = QUOT_W'(prod >> DIV_SHIFT);
        return v[SUM_W-1] ? -q : q;
    endfunction

    assign up_ready   = !valid_reg || dn_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // entry into avoidance takes effect for this beat, exit only for the next
    always_comb
    begin
        mode_used = (mode_reg == MODE_MIGRATE && !up_data.front_hit) ? MODE_MIGRATE
                                                                     : MODE_AVOID;
        mode_next = (mode_used == MODE_AVOID
                     && up_data.max_sample < cfg_regs.exit_threshold) ? MODE_MIGRATE
                                                                      : mode_used;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MIGRATE;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_comb
    begin
        scale_next.quot_left  = div_const(up_data.sum_left);
        scale_next.quot_right = div_const(up_data.sum_right);
        scale_next.mode_used  = mode_used;
        scale_next.mode_next  = mode_next;
        scale_next.mig_left   = up_data.mig_left;
        scale_next.mig_right  = up_data.mig_right;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scale_reg <= scale_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = scale_reg;

endmodule

>>> hdl/bam_limit.sv
// offsets, command selection, limit, saturation, result register
module bam_limit (
    input  logic            clk,
    input  logic            rst_n,
    input  bam_pkg::cfg_t   cfg_regs,
    input  logic            up_valid,
    output logic            up_ready,
    input  bam_pkg::scale_t up_data,
    bam_out_if.source       result
);
    import bam_pkg::*;

    localparam calc_t SAT_HI = calc_t'((1 << (OUT_W - 1)) - 1);
    localparam calc_t SAT_LO = calc_t'(-(1 << (OUT_W - 1)));

    logic  valid_reg;
    logic  valid_next;
    logic  load;
    out_t  left_speed_reg;
    out_t  right_speed_reg;
    logic  mode_used_reg;
    logic  mode_next_reg;
    calc_t a;
    calc_t b;
    calc_t x;
    calc_t y;
    calc_t lim;
    calc_t nlim;
    logic  a_pos;
    logic  a_neg;
    logic  b_pos;
    logic  b_neg;

    function automatic out_t saturate(input calc_t v);
        calc_t c;
        c = v;
        if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        return OUT_W'(c);
    endfunction

    assign up_ready   = !valid_reg || result.ready;
    assign load       = up_valid && up_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_comb
    begin
        if (up_data.mode_used == MODE_MIGRATE)
        begin
            a = calc_t'(up_data.mig_left);
            b = calc_t'(up_data.mig_right);
        end
        else
        begin
            a = calc_t'(up_data.quot_left) + calc_t'(cfg_regs.left_offset);
            b = calc_t'(up_data.quot_right) + calc_t'(cfg_regs.right_offset);
        end
    end

    assign lim   = calc_t'({1'b0, cfg_regs.speed_limit});
    assign nlim  = -lim;
    assign a_neg = a[CALC_W-1];
    assign b_neg = b[CALC_W-1];
    assign a_pos = !a_neg && (a != '0);
    assign b_pos = !b_neg && (b != '0);

    // sign-case limit: the wheel that overshoots is clamped, the other keeps the gap; opposite overshoots clamp both
    always_comb
    begin
        x = a;
        y = b;
        if (a_pos && b_pos)
        begin
            if (a > b)
            begin
                if (a > lim)
                begin
                    x = lim;
                    y = lim - (a - b);
                end
            end
            else
            begin
                if (b > lim)
                begin
                    y = lim;
                    x = lim - (b - a);
                end
            end
        end
        else if (a_pos && b_neg)
        begin
            if (a >= lim && b <= nlim)
            begin
                x = lim;
                y = nlim;
            end
            else if (a >= lim)
            begin
                x = lim;
                y = lim - (a - b);
            end
            else if (b <= nlim)
            begin
                x = nlim + (a - b);
                y = nlim;
            end
        end
        else if (a_neg && b_pos)
        begin
            if (a <= nlim && b >= lim)
            begin
                x = nlim;
                y = lim;
            end
            else if (b >= lim)
            begin
                x = lim - (b - a);
                y = lim;
            end
            else if (a <= nlim)
            begin
                x = nlim;
                y = nlim + (b - a);
            end
        end
        else if (a_neg && b_neg)
        begin
            if (a < b)
            begin
                if (a < nlim)
                begin
                    x = nlim;
                    y = nlim + (b - a);
                end
            end
            else
            begin
                if (b < nlim)
                begin
                    x = nlim + (a - b);
                    y = nlim;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_speed_reg  <= saturate(x);
            right_speed_reg <= saturate(y);
            mode_used_reg   <= up_data.mode_used;
            mode_next_reg   <= up_data.mode_next;
        end
    end

    assign result.valid       = valid_reg;
    assign result.left_speed  = left_speed_reg;
    assign result.right_speed = right_speed_reg;
    assign result.mode_used   = mode_used_reg;
    assign result.mode_next   = mode_next_reg;

endmodule

>>> hdl/bam_check.sv
// port-level checks of the mixer and their bind to the top level
module bam_check (
    input logic          clk,
    input logic          rst_n,
    input logic          item_valid,
    input logic          item_ready,
    input logic          result_valid,
    input logic          result_ready,
    input bam_pkg::out_t left_speed,
    input bam_pkg::out_t right_speed,
    input logic          mode_used,
    input logic          mode_next
);
    import bam_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             last_next_reg;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = item_valid && item_ready;
    assign out_beat = result_valid && result_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_beat && !out_beat)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (out_beat && !in_beat)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_next_reg <= MODE_MIGRATE;
        end
        else
        begin
            count_reg <= count_next;
            if (out_beat)
            begin
                last_next_reg <= mode_next;
            end
        end
    end

    // every result beat belongs to an item still in flight
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> count_reg != '0)
        else $error("result beat with no item in flight");

    // the four pipeline stages bound what can be in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // once a beat leaves avoidance pending, the next command comes from avoidance
    a_mode_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && last_next_reg == MODE_AVOID |-> mode_used == MODE_AVOID)
        else $error("mode used does not follow previous mode");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(left_speed)
            && $stable(right_speed) && $stable(mode_used) && $stable(mode_next))
        else $error("stalled result beat changed");

endmodule

bind braitenberg_avoidance_mode_mixer bam_check u_bam_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .left_speed   (result.left_speed),
    .right_speed  (result.right_speed),
    .mode_used    (result.mode_used),
    .mode_next    (result.mode_next)
);

>>> test/braitenberg_avoidance_mode_mixer_tb.sv
// self-checking testbench of the avoidance mode mixer: random frames, register phases, stalls
module braitenberg_avoidance_mode_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bam_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 250;
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
    localparam int RIGHT_GAIN [NUM_SENSORS] = '{-2, 46, 149, 193, 168, -31, -164, -16};
    localparam int LEFT_GAIN [NUM_SENSORS] = '{-16, -164, -31, 168, 193, 149, 46, -2};
    localparam int FRONT_IDX [4] = '{0, 1, 6, 7};

    typedef struct packed {
        sample_t [NUM_SENSORS-1:0] sensor;
        mig_t                      mig_left;
        mig_t                      mig_right;
    } frame_t;

    typedef struct packed {
        out_t left_speed;
        out_t right_speed;
        logic mode_used;
        logic mode_next;
    } wheel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bam_in_if  in_ch ();
    bam_out_if out_ch ();
    bam_cfg_if cfg_ch ();

    braitenberg_avoidance_mode_mixer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch),
        .cfg    (cfg_ch)
    );

    frame_t frame_q [$];
    wheel_t wheel_q [$];
    frame_t cur_frame;
    wheel_t wanted;

    thr_t    avoid_thr = 12'd1800;
    thr_t    exit_thr = 12'd70;
    thr_t    speed_lim = 12'd800;
    offset_t left_off = 11'sd66;
    offset_t right_off = 11'sd72;
    logic    drive_mode = MODE_MIGRATE;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic out_t clamp_out(longint v);
        if (v < -16384)
            return out_t'(-16384);
        if (v > 16383)
            return out_t'(16383);
        return v[OUT_W-1:0];
    endfunction

    // predicted wheel pair for one frame; advances the mode bit
    function automatic wheel_t mix_wheels(frame_t f);
        longint sum_l, sum_r, x, y, d, lim;
        int unsigned peak;
        logic front;
        wheel_t r;
        sum_l = 0;
        sum_r = 0;
        peak = 0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            if (32'(f.sensor[i]) > peak)
                peak = 32'(f.sensor[i]);
            sum_r += longint'(RIGHT_GAIN[i]) * longint'(f.sensor[i]);
            sum_l += longint'(LEFT_GAIN[i]) * longint'(f.sensor[i]);
        end
        sum_l = sum_l / 350 + longint'(left_off);
        sum_r = sum_r / 350 + longint'(right_off);
        front = (f.sensor[0] > avoid_thr) || (f.sensor[1] > avoid_thr) ||
                (f.sensor[6] > avoid_thr) || (f.sensor[7] > avoid_thr);
        if (drive_mode == MODE_MIGRATE && front)
            drive_mode = MODE_AVOID;
        r.mode_used = drive_mode;
        if (drive_mode == MODE_MIGRATE)
        begin
            x = longint'(f.mig_left);
            y = longint'(f.mig_right);
        end
        else
        begin
            x = sum_l;
            y = sum_r;
        end
        lim = longint'(speed_lim);
        // sign-case limit, keeping the difference of the pair unless both pass the limit with opposite signs
        if (x > 0 && y > 0)
        begin
            if (x > y)
            begin
                d = x - y;
                if (x > lim)
                begin
                    x = lim;
                    y = lim - d;
                end
            end
            else
            begin
                d = y - x;
                if (y > lim)
                begin
                    y = lim;
                    x = lim - d;
                end
            end
        end
        else if (x > 0 && y < 0)
        begin
            d = x - y;
            if (x >= lim && y <= -lim)
            begin
                x = lim;
                y = -lim;
            end
            else if (x >= lim)
            begin
                x = lim;
                y = lim - d;
            end
            else if (y <= -lim)
            begin
                x = -lim + d;
                y = -lim;
            end
        end
        else if (x < 0 && y > 0)
        begin
            d = y - x;
            if (x <= -lim && y >= lim)
            begin
                x = -lim;
                y = lim;
            end
            else if (y >= lim)
            begin
                x = lim - d;
                y = lim;
            end
            else if (x <= -lim)
            begin
                x = -lim;
                y = -lim + d;
            end
        end
        else if (x < 0 && y < 0)
        begin
            if (x < y)
            begin
                d = y - x;
                if (x < -lim)
                begin
                    x = -lim;
                    y = -lim + d;
                end
            end
            else
            begin
                d = x - y;
                if (y < -lim)
                begin
                    x = -lim + d;
                    y = -lim;
                end
            end
        end
        if (drive_mode == MODE_AVOID && peak < 32'(exit_thr))
            drive_mode = MODE_MIGRATE;
        r.left_speed = clamp_out(x);
        r.right_speed = clamp_out(y);
        r.mode_next = drive_mode;
        return r;
    endfunction

    function automatic frame_t flat_frame(int level, int ml, int mr);
        frame_t f;
        for (int i = 0; i < NUM_SENSORS; i++)
            f.sensor[i] = level[SAMPLE_W-1:0];
        f.mig_left = ml[MIG_W-1:0];
        f.mig_right = mr[MIG_W-1:0];
        return f;
    endfunction

    // mostly near the speed limit so every limit case gets hit
    function automatic mig_t pick_speed();
        int v;
        if ($urandom_range(3) == 0)
        begin
            v = $urandom_range(8191);
            return v[MIG_W-1:0];
        end
        v = $urandom_range(speed_lim + 40);
        if (v > 4095)
            v = 4095;
        if ($urandom_range(1) == 1)
            v = -v;
        return v[MIG_W-1:0];
    endfunction

    // quiet frames leave avoidance, obstacle frames enter it, the rest is noise
    function automatic frame_t make_frame();
        frame_t f;
        int kind, hi, idx;
        kind = $urandom_range(99);
        if (kind < 35)
            hi = (exit_thr == 0) ? 0 : int'(exit_thr) - 1;
        else if (kind < 90)
            hi = int'(avoid_thr);
        else
            hi = 4095;
        for (int i = 0; i < NUM_SENSORS; i++)
            f.sensor[i] = sample_t'($urandom_range(hi));
        if (kind >= 35 && kind < 60)
        begin
            idx = FRONT_IDX[$urandom_range(3)];
            f.sensor[idx] = (avoid_thr == 4095) ? sample_t'(4095)
                          : sample_t'($urandom_range(4095, avoid_thr + 1));
        end
        f.mig_left = pick_speed();
        f.mig_right = pick_speed();
        return f;
    endfunction

    task automatic write_reg(cfg_addr_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.addr <= idx;
        cfg_ch.wdata <= val;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_AVOID_THR:    avoid_thr = val;
            CFG_EXIT_THR:     exit_thr = val;
            CFG_SPEED_LIMIT:  speed_lim = val;
            CFG_LEFT_OFFSET:  left_off = val[OFFSET_W-1:0];
            CFG_RIGHT_OFFSET: right_off = val[OFFSET_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int avoid, int leave, int lim, int lofs, int rofs);
        write_reg(CFG_AVOID_THR, avoid[CFG_DATA_W-1:0]);
        write_reg(CFG_EXIT_THR, leave[CFG_DATA_W-1:0]);
        write_reg(CFG_SPEED_LIMIT, lim[CFG_DATA_W-1:0]);
        write_reg(CFG_LEFT_OFFSET, lofs[CFG_DATA_W-1:0]);
        write_reg(CFG_RIGHT_OFFSET, rofs[CFG_DATA_W-1:0]);
    endtask

    task automatic drain();
        while (frame_q.size() != 0 || in_ch.valid || wheel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
            frame_q.push_back(make_frame());
        drain();
    endtask

    task automatic report(string field, logic signed [OUT_W-1:0] want,
                          logic signed [OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                wheel_q.push_back(mix_wheels(cur_frame));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_frame = frame_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.sensor_0 <= cur_frame.sensor[0];
                    in_ch.sensor_1 <= cur_frame.sensor[1];
                    in_ch.sensor_2 <= cur_frame.sensor[2];
                    in_ch.sensor_3 <= cur_frame.sensor[3];
                    in_ch.sensor_4 <= cur_frame.sensor[4];
                    in_ch.sensor_5 <= cur_frame.sensor[5];
                    in_ch.sensor_6 <= cur_frame.sensor[6];
                    in_ch.sensor_7 <= cur_frame.sensor[7];
                    in_ch.migrate_left <= cur_frame.mig_left;
                    in_ch.migrate_right <= cur_frame.mig_right;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (wheel_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, left %0d right %0d",
                             $time, out_ch.left_speed, out_ch.right_speed);
                    mismatches++;
                end
                else
                begin
                    wanted = wheel_q.pop_front();
                    report("left_speed", wanted.left_speed, out_ch.left_speed);
                    report("right_speed", wanted.right_speed, out_ch.right_speed);
                    report("mode_used", OUT_W'(wanted.mode_used), OUT_W'(out_ch.mode_used));
                    report("mode_next", OUT_W'(wanted.mode_next), OUT_W'(out_ch.mode_next));
                end
            end
            out_ch.ready <= !(hold_req && !hold_done) &&
                            ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("braitenberg_avoidance_mode_mixer: mismatch");
        $finish;
    end

    initial
    begin
        frame_t f;
        in_ch.valid = 1'b0;
        in_ch.sensor_0 = '0;
        in_ch.sensor_1 = '0;
        in_ch.sensor_2 = '0;
        in_ch.sensor_3 = '0;
        in_ch.sensor_4 = '0;
        in_ch.sensor_5 = '0;
        in_ch.sensor_6 = '0;
        in_ch.sensor_7 = '0;
        in_ch.migrate_left = '0;
        in_ch.migrate_right = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.wdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames at reset settings
        frame_q.push_back(flat_frame(0, 0, 0));
        frame_q.push_back(flat_frame(0, 4095, 4095));
        frame_q.push_back(flat_frame(0, -4096, -4096));
        frame_q.push_back(flat_frame(0, 4095, -4096));
        frame_q.push_back(flat_frame(0, 900, -100));
        frame_q.push_back(flat_frame(0, 100, -900));
        frame_q.push_back(flat_frame(0, -4096, 4095));
        frame_q.push_back(flat_frame(0, -900, 100));
        frame_q.push_back(flat_frame(0, -100, 900));
        frame_q.push_back(flat_frame(0, 0, 4095));
        frame_q.push_back(flat_frame(0, 500, 300));
        f = flat_frame(0, 300, 500);
        f.sensor[0] = 12'd1801;
        frame_q.push_back(f);
        frame_q.push_back(flat_frame(4095, 4095, -4096));
        frame_q.push_back(flat_frame(0, 0, 0));
        f = flat_frame(0, 1, -1);
        f.sensor[1] = 12'd4095;
        frame_q.push_back(f);
        frame_q.push_back(flat_frame(69, -800, 800));
        f = flat_frame(0, 800, 800);
        f.sensor[6] = 12'd1800;
        frame_q.push_back(f);
        f.sensor[6] = 12'd1801;
        frame_q.push_back(f);
        frame_q.push_back(flat_frame(70, 0, 0));
        f = flat_frame(0, 0, 0);
        f.sensor[3] = 12'd4095;
        f.sensor[4] = 12'd4095;
        frame_q.push_back(f);
        f = flat_frame(0, 2730, -2731);
        for (int i = 0; i < NUM_SENSORS; i++)
            f.sensor[i] = (i % 2 == 0) ? 12'hAAA : 12'h555;
        frame_q.push_back(f);
        frame_q.push_back(flat_frame(0, 0, 0));
        f = flat_frame(0, 1234, -4000);
        f.sensor[2] = 12'd4095;
        f.sensor[5] = 12'd4095;
        frame_q.push_back(f);
        f = flat_frame(0, 7, 7);
        f.sensor[7] = 12'd4095;
        frame_q.push_back(f);
        drain();

        set_config(0, 4095, 4095, -1024, 1023);
        run_phase(47, 0);

        // zero speed limit, avoidance never left
        set_config(100, 0, 0, 1023, -1024);
        run_phase(0, 47);

        set_config(4095, 4095, 1, -1, 0);
        run_phase(6, 6);

        set_config(1800, 70, 800, 66, 72);
        hold_req = 1'b1;
        run_phase(0, 0);

        set_config($urandom_range(4095), $urandom_range(300), $urandom_range(4095),
                   $urandom_range(2047), $urandom_range(2047));
        run_phase(0, 47);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && wheel_q.size() == 0)
            $display("braitenberg_avoidance_mode_mixer: match");
        else
            $display("braitenberg_avoidance_mode_mixer: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hdl/bam_pkg.sv
hdl/bam_ifs.sv
hdl/bam_weigh.sv
hdl/bam_scale.sv
hdl/bam_limit.sv
hdl/braitenberg_avoidance_mode_mixer.sv
hdl/bam_check.sv
test/braitenberg_avoidance_mode_mixer_tb.sv
